// ===== src/assert_macros.svh =====
// Assertion macros for the RTL; only the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that the consequence holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/hsv_pkg.sv =====
// Package: constants and types for the hue rotation pipeline.
`timescale 1ns / 1ps
package hsv_pkg;
  localparam int CHAN_BITS_DEF = 16;
  localparam int FRAC_BITS = 16;
  localparam int SHIFT_BITS = 19;
  localparam logic [SHIFT_BITS-1:0] HUE_TURN = 19'd393216;

  typedef enum logic [2:0] {
    MAX_RED   = 3'b001,
    MAX_GREEN = 3'b010,
    MAX_BLUE  = 3'b100
  } max_sel_t;
endpackage

// ===== src/hsv_hue_rotation_top.sv =====
// Top level: RGB hue rotation through HSV, one pixel per clock.
//   channel  | direction | ports
//   request  | in        | start, red_in, green_in, blue_in (busy is out)
//   result   | out       | done, red_out, green_out, blue_out
//   config   | in        | cfg_valid, cfg_data (cfg_ready is out)
// One pixel accepted per cycle; busy is held low.
// The FRAC_BITS + 1 divider stages sit between stage 2 and stage 3.
// Reset clears the valid line and sets the hue shift to zero.
// No stalls: the receiver takes each result in the cycle done is high.
`timescale 1ns / 1ps
module hsv_hue_rotation_top import hsv_pkg::*; #(
  parameter int CHANNEL_BITS = CHAN_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [CHANNEL_BITS-1:0] red_in,
  input  logic [CHANNEL_BITS-1:0] green_in,
  input  logic [CHANNEL_BITS-1:0] blue_in,
  output logic                    done,
  output logic [CHANNEL_BITS-1:0] red_out,
  output logic [CHANNEL_BITS-1:0] green_out,
  output logic [CHANNEL_BITS-1:0] blue_out,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SHIFT_BITS-1:0]   cfg_data
);
`include "assert_macros.svh"
  localparam int CB = CHANNEL_BITS;
  localparam int SIDE = 3 * CB + 2 + 3 + CB;

  logic [SHIFT_BITS-1:0] hue_shift;
  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_shift <= '0;
    end else if (cfg_valid && cfg_ready) begin
      hue_shift <= (cfg_data >= HUE_TURN) ? cfg_data - HUE_TURN : cfg_data;
    end
  end

  // Stage 1: max, min, selection.
  logic          s1_v;
  logic [CB-1:0] s1_r, s1_g, s1_b, s1_hi, s1_lo;
  max_sel_t      s1_sel;
  always_ff @(posedge clk) begin
    logic [CB-1:0] hi, lo;
    hi = red_in;
    lo = red_in;
    if (green_in > hi) hi = green_in;
    if (blue_in > hi) hi = blue_in;
    if (green_in < lo) lo = green_in;
    if (blue_in < lo) lo = blue_in;
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start && !busy;
    end
    s1_r <= red_in;
    s1_g <= green_in;
    s1_b <= blue_in;
    s1_hi <= hi;
    s1_lo <= lo;
    if (hi == red_in) s1_sel <= MAX_RED;
    else if (hi == green_in) s1_sel <= MAX_GREEN;
    else s1_sel <= MAX_BLUE;
  end

  // Stage 2: difference, sign and sector base.
  logic          s2_v, s2_neg;
  logic [CB-1:0] s2_diff, s2_c;
  logic [2:0]    s2_base;
  logic [CB-1:0] s2_r, s2_g, s2_b, s2_lo;
  always_ff @(posedge clk) begin
    logic [CB-1:0] pos, ng;
    case (s1_sel)
      MAX_RED:   begin pos = s1_g; ng = s1_b; end
      MAX_GREEN: begin pos = s1_b; ng = s1_r; end
      default:   begin pos = s1_r; ng = s1_g; end
    endcase
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_neg  <= pos < ng;
    s2_diff <= (pos >= ng) ? pos - ng : ng - pos;
    s2_c    <= s1_hi - s1_lo;
    s2_base <= (s1_sel == MAX_RED) ? 3'd0 : (s1_sel == MAX_GREEN) ? 3'd2 : 3'd4;
    s2_r <= s1_r;
    s2_g <= s1_g;
    s2_b <= s1_b;
    s2_lo <= s1_lo;
  end

  logic              d_v;
  logic [FRAC_BITS:0] d_q;
  logic [SIDE-1:0]   d_side;
  hsv_div #(.CHANNEL_BITS(CB), .SIDE_BITS(SIDE)) u_div (
    .clk(clk), .rst(rst), .in_valid(s2_v), .num(s2_diff),
    .den((s2_c == '0) ? {{(CB-1){1'b0}}, 1'b1} : s2_c),
    .side_in({s2_r, s2_g, s2_b, s2_neg, (s2_c == '0), s2_base, s2_lo}),
    .out_valid(d_v), .quot(d_q), .side_out(d_side)
  );

  logic [CB-1:0] d_r, d_g, d_b, d_lo;
  logic          d_neg, d_gray;
  logic [2:0]    d_base;
  assign {d_r, d_g, d_b, d_neg, d_gray, d_base, d_lo} = d_side;
  // Chroma regenerated from lo and the channels: c = max - lo.
  logic [CB-1:0] d_c;
  always_comb begin
    d_c = d_r;
    if (d_g > d_c) d_c = d_g;
    if (d_b > d_c) d_c = d_b;
    d_c = d_c - d_lo;
  end

  // Stage 3: hue plus shift, modulo turn.
  logic                  s3_v, s3_gray;
  logic [SHIFT_BITS-1:0] s3_h;
  logic [CB-1:0]         s3_r, s3_g, s3_b, s3_lo, s3_c;
  always_ff @(posedge clk) begin
    logic [SHIFT_BITS+1:0] h;
    h = {d_base, {FRAC_BITS{1'b0}}};
    if (d_neg) h = h + HUE_TURN - d_q;
    else h = h + d_q;
    h = h + hue_shift;
    if (h >= {HUE_TURN, 1'b0}) h = h - {HUE_TURN, 1'b0};
    if (h >= HUE_TURN) h = h - HUE_TURN;
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= d_v;
    end
    s3_h <= h[SHIFT_BITS-1:0];
    s3_gray <= d_gray;
    s3_r <= d_r;
    s3_g <= d_g;
    s3_b <= d_b;
    s3_lo <= d_lo;
    s3_c <= d_c;
  end

  // Stage 4: secondary component multiply.
  logic                  s4_v, s4_gray;
  logic [2:0]            s4_sec;
  logic [CB-1:0]         s4_x;
  logic [CB-1:0]         s4_r, s4_g, s4_b, s4_lo, s4_c;
  always_ff @(posedge clk) begin
    logic [FRAC_BITS:0]       fw;
    logic [CB+FRAC_BITS:0]    p;
    fw = s3_h[FRAC_BITS] ? (17'h10000 - {1'b0, s3_h[FRAC_BITS-1:0]})
                         : {1'b0, s3_h[FRAC_BITS-1:0]};
    p = s3_c * fw + (CB+FRAC_BITS+1)'(32768);
    if (rst) begin
      s4_v <= 1'b0;
    end else begin
      s4_v <= s3_v;
    end
    s4_x <= p[CB+FRAC_BITS-1:FRAC_BITS];
    s4_sec <= s3_h[SHIFT_BITS-1:FRAC_BITS];
    s4_gray <= s3_gray;
    s4_r <= s3_r;
    s4_g <= s3_g;
    s4_b <= s3_b;
    s4_lo <= s3_lo;
    s4_c <= s3_c;
  end

  // Stage 5: place, add offset, clamp.
  function automatic logic [CB-1:0] clampadd(input logic [CB-1:0] a, input logic [CB-1:0] m);
    logic [CB:0] s;
    s = {1'b0, a} + {1'b0, m};
    return s[CB] ? {CB{1'b1}} : s[CB-1:0];
  endfunction

  always_ff @(posedge clk) begin
    logic [CB-1:0] r1, g1, b1;
    case (s4_sec)
      3'd0:    begin r1 = s4_c; g1 = s4_x; b1 = '0; end
      3'd1:    begin r1 = s4_x; g1 = s4_c; b1 = '0; end
      3'd2:    begin r1 = '0; g1 = s4_c; b1 = s4_x; end
      3'd3:    begin r1 = '0; g1 = s4_x; b1 = s4_c; end
      3'd4:    begin r1 = s4_x; g1 = '0; b1 = s4_c; end
      default: begin r1 = s4_c; g1 = '0; b1 = s4_x; end
    endcase
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_v;
    end
    red_out   <= s4_gray ? s4_r : clampadd(r1, s4_lo);
    green_out <= s4_gray ? s4_g : clampadd(g1, s4_lo);
    blue_out  <= s4_gray ? s4_b : clampadd(b1, s4_lo);
  end

  `ASSERT_IMPL(a_hue_range, clk, rst, s3_v, s3_h < HUE_TURN)
  `ASSERT_NEXT(a_done_follow, clk, rst, s4_v, done)
  `ASSERT_IMPL(a_gray_eq, clk, rst, done && $past(s4_gray), red_out == $past(s4_r))
endmodule

// ===== src/hsv_div.sv =====
// Pipelined restoring divider: quotient = (num << FRAC_BITS) / den, one bit per stage.
`timescale 1ns / 1ps
module hsv_div import hsv_pkg::*; #(
  parameter int CHANNEL_BITS = CHAN_BITS_DEF,
  parameter int SIDE_BITS = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [CHANNEL_BITS-1:0] num,
  input  logic [CHANNEL_BITS-1:0] den,
  input  logic [SIDE_BITS-1:0]    side_in,
  output logic                    out_valid,
  output logic [FRAC_BITS:0]      quot,
  output logic [SIDE_BITS-1:0]    side_out
);
  localparam int NSTG = FRAC_BITS + 1;
  localparam int RW = CHANNEL_BITS + 1;

  logic                    vld [1:NSTG];
  logic [RW-1:0]           rem [1:NSTG];
  logic [CHANNEL_BITS-1:0] dv  [1:NSTG];
  logic [FRAC_BITS:0]      q   [1:NSTG];
  logic [SIDE_BITS-1:0]    sd  [1:NSTG];

  // Compare num against den first (num <= den), then shift in zeros.
  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    logic                    v_cur;
    logic [RW-1:0]           rsh;
    logic [CHANNEL_BITS-1:0] d_cur;
    logic [FRAC_BITS:0]      q_cur;
    logic [SIDE_BITS-1:0]    s_cur;
    logic [RW:0]             trial;
    if (i == 0) begin : g_first
      assign v_cur = in_valid;
      assign rsh   = {1'b0, num};
      assign d_cur = den;
      assign q_cur = '0;
      assign s_cur = side_in;
    end else begin : g_next
      assign v_cur = vld[i];
      assign rsh   = {rem[i][RW-2:0], 1'b0};
      assign d_cur = dv[i];
      assign q_cur = q[i];
      assign s_cur = sd[i];
    end
    assign trial = {1'b0, rsh} - {2'b0, d_cur};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= v_cur;
      end
      rem[i+1] <= trial[RW] ? rsh : trial[RW-1:0];
      q[i+1]   <= {q_cur[FRAC_BITS-1:0], ~trial[RW]};
      dv[i+1]  <= d_cur;
      sd[i+1]  <= s_cur;
    end
  end

  assign out_valid = vld[NSTG];
  assign quot      = q[NSTG];
  assign side_out  = sd[NSTG];
endmodule

// ===== test/testbench.sv =====
// Testbench for the hue rotation top level: scoreboard check against a bit-exact predictor.
`timescale 1ns / 1ps
module testbench;
  import hsv_pkg::*;

  localparam int CB = 16;
  localparam int LATENCY = FRAC_BITS + 6;
  localparam int WATCHDOG = 20 * LATENCY + 2000;

  typedef struct packed {
    logic [CB-1:0] r;
    logic [CB-1:0] g;
    logic [CB-1:0] b;
  } pixel_t;

  function automatic pixel_t rotate_pixel(pixel_t p, logic [SHIFT_BITS-1:0] shift);
    longint unsigned r, g, b, hi, lo, c, h, base, pos, neg, frac, sec, f, x, turn, one;
    longint unsigned r1, g1, b1, cmax;
    max_sel_t sel;
    pixel_t o;
    one = 64'd1 << FRAC_BITS;
    turn = 6 * one;
    cmax = (64'd1 << CB) - 1;
    r = p.r; g = p.g; b = p.b;
    hi = r; lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    c = hi - lo;
    if (c == 0) return p;
    if (hi == r) sel = MAX_RED;
    else if (hi == g) sel = MAX_GREEN;
    else sel = MAX_BLUE;
    case (sel)
      MAX_RED: begin base = 0; pos = g; neg = b; end
      MAX_GREEN: begin base = 2 * one; pos = b; neg = r; end
      default: begin base = 4 * one; pos = r; neg = g; end
    endcase
    if (pos >= neg) begin
      frac = ((pos - neg) << FRAC_BITS) / c;
      h = (base + frac) % turn;
    end else begin
      frac = ((neg - pos) << FRAC_BITS) / c;
      h = (base + turn - frac) % turn;
    end
    h = (h + (longint'(shift) % turn)) % turn;
    sec = h >> FRAC_BITS;
    f = h & (one - 1);
    if (sec[0] == 1'b0) x = (c * f + (one >> 1)) >> FRAC_BITS;
    else x = (c * (one - f) + (one >> 1)) >> FRAC_BITS;
    case (sec)
      0: begin r1 = c; g1 = x; b1 = 0; end
      1: begin r1 = x; g1 = c; b1 = 0; end
      2: begin r1 = 0; g1 = c; b1 = x; end
      3: begin r1 = 0; g1 = x; b1 = c; end
      4: begin r1 = x; g1 = 0; b1 = c; end
      default: begin r1 = c; g1 = 0; b1 = x; end
    endcase
    r1 += lo; g1 += lo; b1 += lo;
    o.r = (r1 > cmax) ? cmax[CB-1:0] : r1[CB-1:0];
    o.g = (g1 > cmax) ? cmax[CB-1:0] : g1[CB-1:0];
    o.b = (b1 > cmax) ? cmax[CB-1:0] : b1[CB-1:0];
    return o;
  endfunction

  class pixel_board;
    pixel_t pending[$];
    int mismatches;
    int checked;
    logic [SHIFT_BITS-1:0] shift;

    function void note_request(pixel_t p);
      pending.push_back(rotate_pixel(p, shift));
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h", got.r, got.g, got.b);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp %h %h %h got %h %h %h shift %0d",
                   want.r, want.g, want.b, got.r, got.g, got.b, shift);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, cfg_valid = 1'b0, cfg_ready;
  logic [CB-1:0] red_in = '0, green_in = '0, blue_in = '0;
  logic [CB-1:0] red_out, green_out, blue_out;
  logic [SHIFT_BITS-1:0] cfg_data = '0;
  pixel_board board = new();
  int idle_cycles;
  int sent;

  always #2 clk = ~clk;

  hsv_hue_rotation_top #(.CHANNEL_BITS(CB)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .done(done), .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_result('{red_out, green_out, blue_out});
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired");
        $display("FAIL hsv_hue_rotation_top");
        $finish;
      end
    end else idle_cycles <= 0;
  end

  function automatic logic [CB-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CB'($urandom_range(0, 15));
      3: return ~CB'($urandom_range(0, 15));
      default: return CB'($urandom());
    endcase
  endfunction

  task automatic send_pixel(pixel_t p);
    start <= 1'b1;
    red_in <= p.r; green_in <= p.g; blue_in <= p.b;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(p);
    sent++;
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_shift(logic [SHIFT_BITS-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.shift = v;
  endtask

  task automatic random_run(int n);
    pixel_t p;
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && n > 0) begin
        p.r = rand_chan(); p.g = rand_chan(); p.b = rand_chan();
        if ($urandom_range(0, 9) == 0) begin
          p.g = p.r;
          if ($urandom_range(0, 1) == 1'b1) p.b = p.r;
        end
        send_pixel(p);
        burst--; n--;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, LATENCY + 5));
    end
  endtask

  initial begin
    logic [SHIFT_BITS-1:0] shifts[7];
    pixel_t d;
    board.shift = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_pixel('{16'h0000, 16'h0000, 16'h0000});
    send_pixel('{16'hffff, 16'hffff, 16'hffff});
    send_pixel('{16'h1234, 16'h1234, 16'h1234});
    for (int k = 1; k < 8; k++) begin
      d.r = k[0] ? 16'hffff : 16'h0000;
      d.g = k[1] ? 16'hffff : 16'h0000;
      d.b = k[2] ? 16'hffff : 16'h0000;
      send_pixel(d);
    end
    send_pixel('{16'h8000, 16'h8000, 16'h0001});
    send_pixel('{16'h0001, 16'h8000, 16'h8000});
    send_pixel('{16'h8000, 16'h0001, 16'h8000});
    send_pixel('{16'h0001, 16'h0000, 16'h0000});
    send_pixel('{16'hffff, 16'hfffe, 16'h0000});
    write_shift(19'd393215);
    send_pixel('{16'hffff, 16'h0000, 16'h0000});
    send_pixel('{16'hffff, 16'h0000, 16'h0001});
    send_pixel('{16'h0000, 16'hffff, 16'h0000});
    write_shift(19'd65536);
    send_pixel('{16'hffff, 16'h0000, 16'hffff});
    send_pixel('{16'h4000, 16'hc000, 16'h2000});
    shifts = '{19'd0, 19'd393215, 19'd196608, 19'd32768, 19'd1, 19'd300001, 19'd131072};
    for (int i = 0; i < 7; i++) begin
      write_shift(i == 6 ? SHIFT_BITS'($urandom_range(0, 393215)) : shifts[i]);
      random_run(120);
    end
    drain();
    $display("%0d pixels checked over gray, primary, tie and random inputs", board.checked);
    $display("hue shifts covered: zero, one unit, half, opposite, full turn minus one");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("PASS hsv_hue_rotation_top");
    end else begin
      $display("FAIL hsv_hue_rotation_top");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/hsv_pkg.sv
src/hsv_div.sv
src/hsv_hue_rotation_top.sv
test/testbench.sv
